FILE: hdl/wfcd_pkg.sv
// Shared types, codes and default sizes for the wait-for cycle detector.
package wfcd_pkg;

    localparam int MAX_RES_DEF   = 16;
    localparam int NUM_PROCS_DEF = 8;

    localparam int FUNC_W = 3;
    localparam int ID_W   = 32;
    localparam int SLOT_W = 3;
    localparam int RES_W  = ID_W + 1 + SLOT_W;

    localparam logic [FUNC_W-1:0] FUNC_REGISTER = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET_OWN  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_WAIT     = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DONE     = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CHECK    = 3'd4;

    typedef struct packed {
        logic load_item;
        logic wait_wr;
        logic wait_rd;
        logic res_rd;
        logic res_add;
        logic res_set_owner;
        logic key_from_want;
        logic pos_inc;
        logic chk_init;
        logic hop_adv;
        logic start_adv;
        logic out_load;
        logic out_bit;
    } wfcd_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              proc_ok;
        logic              tbl_full;
        logic              scan_end;
        logic              key_match;
        logic              want_zero;
        logic              owner_set;
        logic              slot_is_start;
        logic              slot_out;
        logic              hops_last;
        logic              start_last;
        logic              out_free;
    } wfcd_stat_t;

endpackage

FILE: hdl/wfcd_datapath.sv
// Datapath: item registers, resource table, wait table, chain counters and output register.
module wfcd_datapath
    import wfcd_pkg::*;
#(
    parameter int MAX_RES   = MAX_RES_DEF,
    parameter int NUM_PROCS = NUM_PROCS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [FUNC_W-1:0] func,
    input  logic [ID_W-1:0]   resource_id,
    input  logic [SLOT_W-1:0] proc_index,
    input  logic              owner_valid,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              deadlock_found,
    input  wfcd_cmd_t         cmd,
    output wfcd_stat_t        stat
);

    localparam int AW   = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
    localparam int UW   = $clog2(MAX_RES + 1);
    localparam int WIDX = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int CW   = $clog2(NUM_PROCS + 1);
    localparam int CMPW = (CW > SLOT_W) ? CW : SLOT_W;

    logic [FUNC_W-1:0] func_reg;
    logic [ID_W-1:0]   key_reg;
    logic [SLOT_W-1:0] proc_reg;
    logic              ov_reg;

    logic [RES_W-1:0]  res_mem [MAX_RES];
    logic [RES_W-1:0]  res_q_reg;
    logic [UW-1:0]     used_reg;
    logic [UW-1:0]     pos_reg;
    logic              res_we;
    logic [AW-1:0]     res_waddr;
    logic [RES_W-1:0]  res_wdata;
    logic [ID_W-1:0]   rd_id;
    logic              rd_ov;
    logic [SLOT_W-1:0] rd_slot;

    logic [ID_W-1:0]      wait_mem [NUM_PROCS];
    logic [NUM_PROCS-1:0] wait_vld_reg;
    logic [ID_W-1:0]      wait_q_reg;
    logic                 wait_q_vld_reg;
    logic [WIDX-1:0]      wait_waddr;

    logic [CW-1:0]   start_reg;
    logic [CW-1:0]   hops_reg;
    logic [WIDX-1:0] cur_reg;

    logic out_valid_reg;
    logic deadlock_found_reg;

    assign rd_id   = res_q_reg[RES_W-1 -: ID_W];
    assign rd_ov   = res_q_reg[SLOT_W];
    assign rd_slot = res_q_reg[SLOT_W-1:0];

    assign res_we    = cmd.res_add | cmd.res_set_owner;
    assign res_waddr = cmd.res_add ? used_reg[AW-1:0] : pos_reg[AW-1:0];
    assign res_wdata = cmd.res_add ? {key_reg, 1'b0, {SLOT_W{1'b0}}}
                                   : {key_reg, ov_reg, proc_reg};
    assign wait_waddr = WIDX'(proc_reg);

    // hold the item and the search key
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg <= func;
            key_reg  <= resource_id;
            proc_reg <= proc_index;
            ov_reg   <= owner_valid;
        end
        else if (cmd.key_from_want)
        begin
            key_reg <= wait_q_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_we)
        begin
            res_mem[res_waddr] <= res_wdata;
        end
        if (cmd.res_rd)
        begin
            res_q_reg <= res_mem[pos_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wait_wr)
        begin
            wait_mem[wait_waddr] <= (func_reg == FUNC_DONE) ? '0 : key_reg;
        end
        if (cmd.wait_rd)
        begin
            wait_q_reg <= wait_mem[cur_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_vld_reg   <= '0;
            wait_q_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wait_wr)
            begin
                wait_vld_reg[wait_waddr] <= 1'b1;
            end
            if (cmd.wait_rd)
            begin
                wait_q_vld_reg <= wait_vld_reg[cur_reg];
            end
        end
    end

    // advance the scan position and chain counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            pos_reg   <= '0;
            start_reg <= '0;
            hops_reg  <= '0;
            cur_reg   <= '0;
        end
        else
        begin
            if (cmd.res_add)
            begin
                used_reg <= used_reg + UW'(1);
            end
            if (cmd.load_item || cmd.key_from_want)
            begin
                pos_reg <= '0;
            end
            else if (cmd.pos_inc)
            begin
                pos_reg <= pos_reg + UW'(1);
            end
            if (cmd.chk_init)
            begin
                start_reg <= '0;
                hops_reg  <= '0;
                cur_reg   <= '0;
            end
            else if (cmd.start_adv)
            begin
                start_reg <= start_reg + CW'(1);
                hops_reg  <= '0;
                cur_reg   <= WIDX'(start_reg + CW'(1));
            end
            else if (cmd.hop_adv)
            begin
                hops_reg <= hops_reg + CW'(1);
                cur_reg  <= WIDX'(rd_slot);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            deadlock_found_reg <= cmd.out_bit;
        end
    end

    assign out_valid      = out_valid_reg;
    assign deadlock_found = deadlock_found_reg;

    always_comb
    begin
        stat.func          = func_reg;
        stat.proc_ok       = CMPW'(proc_reg) < CMPW'(NUM_PROCS);
        stat.tbl_full      = used_reg == UW'(MAX_RES);
        stat.scan_end      = pos_reg == used_reg;
        stat.key_match     = rd_id == key_reg;
        stat.want_zero     = !wait_q_vld_reg || (wait_q_reg == '0);
        stat.owner_set     = rd_ov;
        stat.slot_is_start = CMPW'(rd_slot) == CMPW'(start_reg);
        stat.slot_out      = CMPW'(rd_slot) >= CMPW'(NUM_PROCS);
        stat.hops_last     = hops_reg == CW'(NUM_PROCS - 1);
        stat.start_last    = start_reg == CW'(NUM_PROCS - 1);
        stat.out_free      = !out_valid_reg || out_ready;
    end

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(MAX_RES))
        else $error("resource count beyond table size");

    a_add_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_add |-> (used_reg != UW'(MAX_RES)))
        else $error("entry added to a full table");

    a_read_written: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_rd |-> (pos_reg < used_reg))
        else $error("read of an unregistered entry");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken beat");

endmodule

FILE: hdl/wfcd_ctrl.sv
// Controller: sequences lookups, table updates and the chain walk of a check.
module wfcd_ctrl
    import wfcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  wfcd_stat_t stat,
    output wfcd_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN_RD  = 3'd2;
    localparam logic [2:0] S_SCAN_CMP = 3'd3;
    localparam logic [2:0] S_HOP_RD   = 3'd4;
    localparam logic [2:0] S_HOP_CHK  = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       found_reg;
    logic       found_next;
    logic       nxt_start;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        found_next = found_reg;
        nxt_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                found_next = 1'b0;
                case (stat.func)
                    FUNC_REGISTER:
                    begin
                        state_next = stat.tbl_full ? S_FINISH : S_SCAN_RD;
                    end
                    FUNC_SET_OWN:
                    begin
                        state_next = S_SCAN_RD;
                    end
                    FUNC_WAIT, FUNC_DONE:
                    begin
                        cmd.wait_wr = stat.proc_ok;
                        state_next  = S_FINISH;
                    end
                    FUNC_CHECK:
                    begin
                        cmd.chk_init = 1'b1;
                        state_next   = S_HOP_RD;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                if (stat.scan_end)
                begin
                    if (stat.func == FUNC_CHECK)
                    begin
                        nxt_start = 1'b1;
                    end
                    else
                    begin
                        cmd.res_add = (stat.func == FUNC_REGISTER);
                        state_next  = S_FINISH;
                    end
                end
                else
                begin
                    cmd.res_rd = 1'b1;
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                if (!stat.key_match)
                begin
                    cmd.pos_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
                else if (stat.func != FUNC_CHECK)
                begin
                    cmd.res_set_owner = (stat.func == FUNC_SET_OWN);
                    state_next        = S_FINISH;
                end
                else if (!stat.owner_set)
                begin
                    nxt_start = 1'b1;
                end
                else if (stat.slot_is_start)
                begin
                    found_next = 1'b1;
                    state_next = S_FINISH;
                end
                else if (stat.slot_out || stat.hops_last)
                begin
                    nxt_start = 1'b1;
                end
                else
                begin
                    cmd.hop_adv = 1'b1;
                    state_next  = S_HOP_RD;
                end
            end
            S_HOP_RD:
            begin
                cmd.wait_rd = 1'b1;
                state_next  = S_HOP_CHK;
            end
            S_HOP_CHK:
            begin
                if (stat.want_zero)
                begin
                    nxt_start = 1'b1;
                end
                else
                begin
                    cmd.key_from_want = 1'b1;
                    state_next        = S_SCAN_RD;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_bit  = found_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // drop this chain and move to the next starting process; past the last one, finish with no cycle found
        if (nxt_start)
        begin
            if (stat.start_last)
            begin
                found_next = 1'b0;
                state_next = S_FINISH;
            end
            else
            begin
                cmd.start_adv = 1'b1;
                state_next    = S_HOP_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
        end
    end

endmodule

FILE: hdl/wait_for_cycle_detector_core.sv
// Top level of the wait-for cycle detector: controller and datapath.
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_ready  func, resource_id, proc_index, owner_valid
//  out      output     out_valid/out_ready  deadlock_found
//
// One item at a time. Wait updates and unused codes go straight to the result; register and set owner
// compare the entries in turn; register adds the id when absent and the table is not full.
// A check takes up to NUM_PROCS starts x NUM_PROCS hops, each hop a wait-table read plus a table
// search that compares the entries in turn.
// Reset clears the entry count and wait table valid bits at once, no sweep.
// A stalled result holds the block in its last state.
module wait_for_cycle_detector_core
    import wfcd_pkg::*;
#(
    parameter int MAX_RES   = MAX_RES_DEF,
    parameter int NUM_PROCS = NUM_PROCS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FUNC_W-1:0] func,
    input  logic [ID_W-1:0]   resource_id,
    input  logic [SLOT_W-1:0] proc_index,
    input  logic              owner_valid,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              deadlock_found
);

    wfcd_cmd_t  cmd;
    wfcd_stat_t stat;

    wfcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wfcd_datapath #(
        .MAX_RES   (MAX_RES),
        .NUM_PROCS (NUM_PROCS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .func           (func),
        .resource_id    (resource_id),
        .proc_index     (proc_index),
        .owner_valid    (owner_valid),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .deadlock_found (deadlock_found),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule

FILE: verif/wait_for_cycle_detector_core_tb.sv
// Self-checking testbench for the wait-for cycle detector core: directed, chain and random traffic.
module wait_for_cycle_detector_core_tb;
    import wfcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_RES     = MAX_RES_DEF;
    localparam int NUM_PROCS   = NUM_PROCS_DEF;
    localparam int POOL_N      = 16;
    localparam int DRAIN_CYCLES = 2500;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              found;
    } verdict_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   resource_id;
    logic [SLOT_W-1:0] proc_index;
    logic              owner_valid;
    logic              out_valid;
    logic              out_ready;
    logic              deadlock_found;

    logic [ID_W-1:0]   res_key [MAX_RES];
    logic              res_own_v [MAX_RES];
    logic [SLOT_W-1:0] res_own_slot [MAX_RES];
    int                res_count;
    logic [ID_W-1:0]   wait_id [NUM_PROCS];

    logic [ID_W-1:0]   id_pool [POOL_N];
    verdict_t          verdict_q [$];
    int                err_count;
    int                sent_count;
    int                hold_off;
    bit                no_idle;

    wait_for_cycle_detector_core #(
        .MAX_RES   (MAX_RES),
        .NUM_PROCS (NUM_PROCS)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .resource_id    (resource_id),
        .proc_index     (proc_index),
        .owner_valid    (owner_valid),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .deadlock_found (deadlock_found)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("wait_for_cycle_detector_core_tb: FAIL");
        $finish;
    end

    function automatic int draw_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic int find_res(logic [ID_W-1:0] id);
        for (int i = 0; i < res_count; i++)
        begin
            if (res_key[i] == id)
                return i;
        end
        return MAX_RES;
    endfunction

    function automatic logic cycle_present();
        int cur;
        int pos;
        int who;
        for (int s = 0; s < NUM_PROCS; s++)
        begin
            if (wait_id[s] == '0)
                continue;
            cur = s;
            for (int h = 0; h < NUM_PROCS; h++)
            begin
                if (wait_id[cur] == '0)
                    break;
                pos = find_res(wait_id[cur]);
                if (pos >= MAX_RES)
                    break;
                if (!res_own_v[pos])
                    break;
                who = int'(res_own_slot[pos]);
                if (who == s)
                    return 1'b1;
                if (who >= NUM_PROCS)
                    break;
                cur = who;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic apply_op(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                                      logic [SLOT_W-1:0] p, logic ov);
        int   pos;
        logic found;
        found = 1'b0;
        case (f)
            FUNC_REGISTER:
                if (res_count < MAX_RES && find_res(id) == MAX_RES)
                begin
                    res_key[res_count]      = id;
                    res_own_v[res_count]    = 1'b0;
                    res_own_slot[res_count] = '0;
                    res_count++;
                end
            FUNC_SET_OWN:
            begin
                pos = find_res(id);
                if (pos < MAX_RES)
                begin
                    res_own_v[pos]    = ov;
                    res_own_slot[pos] = p;
                end
            end
            FUNC_WAIT:
                if (int'(p) < NUM_PROCS)
                    wait_id[p] = id;
            FUNC_DONE:
                if (int'(p) < NUM_PROCS)
                    wait_id[p] = '0;
            FUNC_CHECK:
                found = cycle_present();
            default:
                found = 1'b0;
        endcase
        return found;
    endfunction

    function automatic void mix(ref int a[MAX_RES], input int n);
        int j;
        int t;
        for (int i = n - 1; i > 0; i--)
        begin
            j    = $urandom_range(0, i);
            t    = a[i];
            a[i] = a[j];
            a[j] = t;
        end
    endfunction

    task automatic flag_mismatch(input string what, input logic exp_bit, input logic got_bit);
        err_count++;
        if (err_count <= 10)
            $display("%0t mismatch: %s, deadlock_found expected %0b got %0b",
                     $realtime, what, exp_bit, got_bit);
    endtask

    task automatic send_op(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id,
                           input logic [SLOT_W-1:0] p, input logic ov);
        int       gap;
        verdict_t v;
        gap = no_idle ? 0 : draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= f;
        resource_id <= id;
        proc_index  <= p;
        owner_valid <= ov;
        v.func  = f;
        v.found = apply_op(f, id, p, ov);
        verdict_q.push_back(v);
        if (f <= FUNC_CHECK)
            sent_count++;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_results();
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_op();
        int                pick;
        logic [ID_W-1:0]   id;
        logic [SLOT_W-1:0] p;
        logic              ov;
        pick = $urandom_range(0, 99);
        p    = SLOT_W'($urandom_range(0, NUM_PROCS - 1));
        ov   = ($urandom_range(0, 1) != 0);
        id   = ($urandom_range(0, 4) == 0) ? $urandom() : id_pool[$urandom_range(0, POOL_N - 1)];
        if (pick < 12)
            send_op(FUNC_REGISTER, id, p, ov);
        else if (pick < 37)
            send_op(FUNC_SET_OWN, id, p, $urandom_range(0, 4) != 0);
        else if (pick < 62)
            send_op(FUNC_WAIT, id, p, ov);
        else if (pick < 77)
            send_op(FUNC_DONE, id, p, ov);
        else if (pick < 95)
            send_op(FUNC_CHECK, id, p, ov);
        else
            send_op(FUNC_W'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO)), id, p, ov);
    endtask

    // close the ring most of the time, leave it open otherwise
    task automatic run_chain();
        int slots [MAX_RES];
        int rows [MAX_RES];
        int k;
        bit closed;
        if (res_count < 2)
            return;
        for (int i = 0; i < MAX_RES; i++)
        begin
            slots[i] = i % NUM_PROCS;
            rows[i]  = i;
        end
        mix(slots, NUM_PROCS);
        mix(rows, res_count);
        k = $urandom_range(2, NUM_PROCS);
        if (k > res_count)
            k = res_count;
        closed = $urandom_range(0, 2) != 0;
        for (int i = 0; i < k; i++)
            send_op(FUNC_SET_OWN, res_key[rows[i]], SLOT_W'(slots[i]), closed || i != 0);
        for (int i = 0; i < k; i++)
            send_op(FUNC_WAIT, res_key[rows[(i + 1) % k]], SLOT_W'(slots[i]),
                    $urandom_range(0, 1) != 0);
        send_op(FUNC_CHECK, $urandom(), SLOT_W'($urandom_range(0, 7)),
                $urandom_range(0, 1) != 0);
        for (int i = 0; i < k; i++)
        begin
            if ($urandom_range(0, 1))
                send_op(FUNC_DONE, $urandom(), SLOT_W'(slots[i]), $urandom_range(0, 1) != 0);
        end
        if ($urandom_range(0, 1))
            send_op(FUNC_CHECK, $urandom(), SLOT_W'($urandom_range(0, 7)),
                    $urandom_range(0, 1) != 0);
    endtask

    task automatic test_directed();
        send_op(FUNC_CHECK,    32'h0000_0000, 3'd0, 1'b0);
        send_op(FUNC_SPARE_LO, 32'hFFFF_FFFF, 3'd7, 1'b1);
        send_op(FUNC_SPARE_HI, 32'h0000_0000, 3'd0, 1'b0);
        send_op(FUNC_REGISTER, 32'h0000_0000, 3'd0, 1'b0);
        send_op(FUNC_REGISTER, 32'hFFFF_FFFF, 3'd7, 1'b1);
        send_op(FUNC_REGISTER, 32'h0000_0001, 3'd0, 1'b0);
        send_op(FUNC_REGISTER, 32'h0000_0001, 3'd5, 1'b1);
        send_op(FUNC_SET_OWN,  32'h1234_5678, 3'd2, 1'b1);
        send_op(FUNC_SET_OWN,  32'h0000_0000, 3'd0, 1'b1);
        send_op(FUNC_WAIT,     32'h0000_0000, 3'd0, 1'b0);
        send_op(FUNC_CHECK,    32'h0000_0000, 3'd0, 1'b0);
        send_op(FUNC_SET_OWN,  32'hFFFF_FFFF, 3'd7, 1'b1);
        send_op(FUNC_SET_OWN,  32'h0000_0001, 3'd0, 1'b1);
        send_op(FUNC_WAIT,     32'hFFFF_FFFF, 3'd0, 1'b0);
        send_op(FUNC_WAIT,     32'h0000_0001, 3'd7, 1'b1);
        send_op(FUNC_CHECK,    32'hFFFF_FFFF, 3'd7, 1'b1);
        send_op(FUNC_DONE,     32'h0000_0000, 3'd7, 1'b0);
        send_op(FUNC_CHECK,    32'h0000_0000, 3'd0, 1'b0);
        send_op(FUNC_WAIT,     32'h0000_0001, 3'd7, 1'b0);
        send_op(FUNC_SET_OWN,  32'h0000_0001, 3'd0, 1'b0);
        send_op(FUNC_CHECK,    32'h0000_0000, 3'd0, 1'b0);
        send_op(FUNC_SET_OWN,  32'hFFFF_FFFF, 3'd0, 1'b1);
        send_op(FUNC_CHECK,    32'h0000_0000, 3'd0, 1'b0);
        send_op(FUNC_DONE,     32'h0000_0000, 3'd0, 1'b0);
        send_op(FUNC_DONE,     32'h0000_0000, 3'd7, 1'b0);
    endtask

    task automatic test_random_traffic(input int target);
        int stop;
        stop = sent_count + target;
        while (sent_count < stop)
        begin
            no_idle = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 1))
                run_chain();
            else
                repeat ($urandom_range(3, 12)) random_op();
        end
        no_idle = 1'b0;
    endtask

    task automatic test_table_full();
        while (res_count < MAX_RES)
            send_op(FUNC_REGISTER, $urandom(), SLOT_W'($urandom_range(0, 7)),
                    $urandom_range(0, 1) != 0);
        send_op(FUNC_REGISTER, res_key[0], 3'd1, 1'b1);
        send_op(FUNC_REGISTER, ~res_key[1], 3'd6, 1'b0);
        send_op(FUNC_SET_OWN, ~res_key[1], 3'd3, 1'b1);
        send_op(FUNC_WAIT, ~res_key[1], 3'd3, 1'b1);
        send_op(FUNC_CHECK, $urandom(), 3'd4, 1'b0);
    endtask

    task automatic test_receiver_hold();
        hold_off = HOLD_CYCLES;
        no_idle  = 1'b1;
        repeat (30) random_op();
        no_idle  = 1'b0;
    endtask

    task automatic test_sender_pause();
        repeat (10) random_op();
        in_valid <= 1'b0;
        wait_results();
        run_chain();
    endtask

    initial
    begin
        int stall;
        stall     = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                    flag_mismatch("beat with nothing pending", 1'b0, deadlock_found);
                else if (deadlock_found !== verdict_q[0].found)
                begin
                    flag_mismatch($sformatf("func %0d", verdict_q[0].func),
                                  verdict_q[0].found, deadlock_found);
                    void'(verdict_q.pop_front());
                end
                else
                    void'(verdict_q.pop_front());
                stall = no_idle ? 0 : draw_gap();
            end
            if (hold_off > 0)
            begin
                stall    = hold_off;
                hold_off = 0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        func        = FUNC_REGISTER;
        resource_id = '0;
        proc_index  = '0;
        owner_valid = 1'b0;
        res_count   = 0;
        err_count   = 0;
        sent_count  = 0;
        hold_off    = 0;
        no_idle     = 1'b0;
        for (int i = 0; i < NUM_PROCS; i++)
            wait_id[i] = '0;
        id_pool[0] = 32'h0000_0000;
        id_pool[1] = 32'hFFFF_FFFF;
        id_pool[2] = 32'h0000_0001;
        for (int i = 3; i < POOL_N; i++)
            id_pool[i] = $urandom();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(300);
        test_table_full();
        test_receiver_hold();
        test_sender_pause();
        test_random_traffic(650);

        in_valid <= 1'b0;
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("wait_for_cycle_detector_core_tb: PASS");
        else
            $display("wait_for_cycle_detector_core_tb: FAIL");
        $finish;
    end

endmodule

FILE: files.f
hdl/wfcd_pkg.sv
hdl/wfcd_datapath.sv
hdl/wfcd_ctrl.sv
hdl/wait_for_cycle_detector_core.sv
verif/wait_for_cycle_detector_core_tb.sv
